### rtl/core/ctw_pkg.sv
// Shared constants, command codes and the screen store request type of the text console.
package ctw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;
  localparam int POS_W  = 11;
  // Wide enough for any linear cell index, and for the cell count itself.
  localparam int LIN_W  = 13;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [LIN_W-1:0]  waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [LIN_W-1:0]  raddr;
  } ram_req_t;

endpackage

### rtl/core/ctw_screen_ram.sv
// Screen store: one write port and one registered read port.
module ctw_screen_ram
  import ctw_pkg::*;
#(
  parameter int DEPTH = DEF_COLUMNS * DEF_ROWS
) (
  input  logic              clk,
  input  ram_req_t          req,
  output logic [CELL_W-1:0] rdata
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr[ADDR_W-1:0]];
    end
  end

endmodule

### rtl/core/ctw_sequencer.sv
// Command sequencer: cursor, store sweeps for scroll and clear, and the result register.
module ctw_sequencer
  import ctw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  column,
  input  logic [ATTR_W-1:0] attribute,
  output ram_req_t          ram_req,
  input  logic [CELL_W-1:0] ram_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  cursor_position,
  output logic [CELL_W-1:0] cell_value,
  output logic              scrolled
);

  localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int MOVE_COUNT = CELL_COUNT - SCREEN_COLUMNS;

  localparam logic [LIN_W-1:0]  CELLS_L  = LIN_W'(CELL_COUNT);
  localparam logic [LIN_W-1:0]  MOVE_L   = LIN_W'(MOVE_COUNT);
  localparam logic [LIN_W-1:0]  COLS_L   = LIN_W'(SCREEN_COLUMNS);
  localparam logic [ROW_W:0]    ROWS_W1  = (ROW_W+1)'(SCREEN_ROWS);
  localparam logic [COL_W:0]    COLS_W1  = (COL_W+1)'(SCREEN_COLUMNS);
  localparam logic [ROW_W-1:0]  ROWS_M1  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0]  COLS_M1  = COL_W'(SCREEN_COLUMNS - 1);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_BLANK  = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t            state;
  logic [LIN_W-1:0]  idx;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [CELL_W-1:0] res_cell;
  logic              res_scrolled;

  logic              accept;
  logic [LIN_W-1:0]  cur_lin;
  logic [COL_W:0]    col_inc;
  logic              col_wrap;
  logic              last_row;
  logic [ROW_W-1:0]  row_clamped;
  logic [COL_W-1:0]  col_clamped;

  function automatic logic [LIN_W-1:0] cell_index(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return LIN_W'(r) * COLS_L + LIN_W'(c);
  endfunction

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign cur_lin     = cell_index(cur_row, cur_col);
  assign col_inc     = {1'b0, cur_col} + 1'b1;
  assign col_wrap    = (col_inc >= COLS_W1);
  assign last_row    = (cur_row == ROWS_M1);
  assign row_clamped = ({1'b0, row} >= ROWS_W1) ? ROWS_M1 : row;
  assign col_clamped = ({1'b0, column} >= COLS_W1) ? COLS_M1 : column;

  always_comb begin
    ram_req = '0;
    unique case (state)
      S_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx;
        ram_req.wdata = {ATTR_RESET, SPACE_CODE};
      end
      S_CLEAR, S_BLANK: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx;
        ram_req.wdata = {attribute, SPACE_CODE};
      end
      S_IDLE: begin
        if (accept && command == CMD_PUT && char_code != NEWLINE_CODE) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = cur_lin;
          ram_req.wdata = {attribute, char_code};
        end
        if (accept && command == CMD_READ) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = cell_index(row_clamped, col_clamped);
        end
      end
      S_SCROLL: begin
        // Each cycle reads one row ahead and writes back the cell read the cycle before.
        ram_req.re    = (idx < MOVE_L);
        ram_req.raddr = idx + COLS_L;
        ram_req.we    = (idx != '0);
        ram_req.waddr = idx - 1'b1;
        ram_req.wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      idx       <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      out_valid <= 1'b0;
    end else begin
      // In the finish state the output register is reloaded instead.
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (idx == CELLS_L - 1'b1) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_cell     <= '0;
            res_scrolled <= 1'b0;
            unique case (command)
              CMD_PUT: begin
                if (char_code == NEWLINE_CODE || col_wrap) begin
                  cur_col <= '0;
                  if (last_row) begin
                    res_scrolled <= 1'b1;
                    idx          <= '0;
                    state        <= S_SCROLL;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                    state   <= S_FINISH;
                  end
                end else begin
                  cur_col <= col_inc[COL_W-1:0];
                  state   <= S_FINISH;
                end
              end
              CMD_SET: begin
                cur_row <= row_clamped;
                cur_col <= col_clamped;
                state   <= S_FINISH;
              end
              CMD_CLEAR: begin
                cur_row <= '0;
                cur_col <= '0;
                idx     <= '0;
                state   <= S_CLEAR;
              end
              default: begin
                state <= S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          res_cell <= ram_rdata;
          state    <= S_FINISH;
        end
        S_SCROLL: begin
          // At the end idx already points at the first cell of the bottom row.
          if (idx == MOVE_L) begin
            state <= S_BLANK;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_BLANK, S_CLEAR: begin
          if (idx == CELLS_L - 1'b1) begin
            state <= S_FINISH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            cursor_position <= cur_lin[POS_W-1:0];
            cell_value      <= res_cell;
            scrolled        <= res_scrolled;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cur_row} < ROWS_W1) && ({1'b0, cur_col} < COLS_W1))
    else $error("cursor left the screen");

  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> !in_ready)
    else $error("item accepted during the clearing pass");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (ram_req.waddr < CELLS_L))
    else $error("store write beyond the last cell");

  a_scroll_stride: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL && ram_req.re && ram_req.we) |->
      (ram_req.raddr == ram_req.waddr + COLS_L + 1'b1))
    else $error("scroll read and write drifted apart");

  a_scroll_home: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && res_scrolled) |-> (last_row && cur_col == '0))
    else $error("scroll finished with the cursor off the bottom row start");

endmodule

### rtl/core/text_console_writer.sv
// Top level of the text console: attribute register, sequencer and screen store.
//
//   channel  signals                                         direction
//   in       in_valid/in_ready, command, char_code, row,     into block
//            column
//   out      out_valid/out_ready, cursor_position,           out of block
//            cell_value, scrolled
//   cfg      cfg_valid/cfg_ready, text_attribute             into block
//
// Put and set cursor pass through the finish state; read cell also passes through the read
// state for the registered store read. Clear rewrites every cell, and a scrolling put moves
// each row up and blanks the bottom row, through the one write port of the screen store.
// After reset a clearing pass fills the store with spaces; in_ready stays low meanwhile,
// configuration writes are taken as ever.
// A result waits in an output register; the next item is accepted while it waits.
module text_console_writer
  import ctw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  column,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  cursor_position,
  output logic [CELL_W-1:0] cell_value,
  output logic              scrolled,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ATTR_W-1:0] text_attribute
);

  logic [ATTR_W-1:0] attribute;
  ram_req_t          ram_req;
  logic [CELL_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attribute <= text_attribute;
    end
  end

  ctw_sequencer #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_sequencer (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .char_code       (char_code),
    .row             (row),
    .column          (column),
    .attribute       (attribute),
    .ram_req         (ram_req),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_position (cursor_position),
    .cell_value      (cell_value),
    .scrolled        (scrolled)
  );

  ctw_screen_ram #(
    .DEPTH (SCREEN_ROWS * SCREEN_COLUMNS)
  ) u_screen_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

### sim/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: directed and random commands.
module tb_text_console_writer;
  import ctw_pkg::*;

  localparam int COLS  = DEF_COLUMNS;
  localparam int ROWS  = DEF_ROWS;
  localparam int CELLS = COLS * ROWS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int RANDOM_PER_PHASE = 260;

  typedef struct {
    cmd_t              op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  r;
    logic [COL_W-1:0]  c;
  } console_req_t;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_val;
    logic              scrolled;
  } console_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        command = CMD_PUT;
  logic [CHAR_W-1:0] char_code = '0;
  logic [ROW_W-1:0]  row = '0;
  logic [COL_W-1:0]  column = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_value;
  logic              scrolled;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ATTR_W-1:0] text_attribute = ATTR_RESET;

  console_req_t    pending_reqs[$];
  console_result_t expected_results[$];
  console_req_t    on_bus;

  // Shadow copy of the console state.
  logic [CELL_W-1:0] shadow_cells [0:CELLS-1];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [ATTR_W-1:0] shadow_attr;

  int phase = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  text_console_writer #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS   (ROWS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .char_code      (char_code),
    .row            (row),
    .column         (column),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_position(cursor_position),
    .cell_value     (cell_value),
    .scrolled       (scrolled),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .text_attribute (text_attribute)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lim);
    return (v >= lim) ? lim - 1 : v;
  endfunction

  // Moves the cursor to the start of the next line and scrolls on the last row.
  function automatic logic shadow_next_line();
    cur_col = 0;
    if (cur_row >= ROWS - 1) begin
      for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) shadow_cells[i] = {shadow_attr, SPACE_CODE};
      cur_row = ROWS - 1;
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  function automatic void apply_console_command(console_req_t q);
    console_result_t res;
    int unsigned     idx;
    res.cell_val = '0;
    res.scrolled = 1'b0;
    case (q.op)
      CMD_PUT: begin
        if (q.ch == NEWLINE_CODE) begin
          res.scrolled = shadow_next_line();
        end else begin
          idx = cur_row * COLS + cur_col;
          shadow_cells[idx] = {shadow_attr, q.ch};
          cur_col++;
          if (cur_col >= COLS) res.scrolled = shadow_next_line();
        end
      end
      CMD_SET: begin
        cur_row = clamp_to(q.r, ROWS);
        cur_col = clamp_to(q.c, COLS);
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_attr, SPACE_CODE};
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        idx = clamp_to(q.r, ROWS) * COLS + clamp_to(q.c, COLS);
        res.cell_val = shadow_cells[idx];
      end
    endcase
    res.pos = POS_W'(cur_row * COLS + cur_col);
    expected_results.push_back(res);
  endfunction

  function automatic int sender_idle_pct();
    return (phase == 1) ? 14 : (phase == 2) ? 86 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    return (phase == 1) ? 86 : (phase == 2) ? 14 : 0;
  endfunction

  // Driver: presents queued items and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_console_command(on_bus);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          on_bus = pending_reqs.pop_front();
          in_valid  <= 1'b1;
          command   <= on_bus.op;
          char_code <= on_bus.ch;
          row       <= on_bus.r;
          column    <= on_bus.c;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: pos=%0d cell=%h scrolled=%b",
                     cursor_position, cell_value, scrolled);
        end else begin
          want = expected_results.pop_front();
          if (cursor_position !== want.pos || cell_value !== want.cell_val ||
              scrolled !== want.scrolled) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result differs: pos %0d/%0d cell %h/%h scrolled %b/%b (exp/act)",
                       want.pos, cursor_position, want.cell_val, cell_value,
                       want.scrolled, scrolled);
          end
        end
      end
      // Once in the last phase the receiver stops for a long stretch to back up the input.
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (phase == 3 && !hold_done && expected_results.size() > 0) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("text_console_writer: mismatch");
      $finish;
    end
  end

  task automatic add_req(input cmd_t op, input int ch, input int r, input int c);
    console_req_t q;
    q.op = op;
    q.ch = CHAR_W'(ch);
    q.r  = ROW_W'(r);
    q.c  = COL_W'(c);
    pending_reqs.push_back(q);
  endtask

  task automatic write_text_attribute(input logic [ATTR_W-1:0] v);
    @(posedge clk);
    cfg_valid      <= 1'b1;
    text_attribute <= v;
    do @(posedge clk); while (!cfg_ready);
    shadow_attr = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_console_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Mostly lines of text placed with set cursor, read back, with clears and noise mixed in.
  task automatic gen_random_phase(input int n);
    int added;
    int sel;
    int r;
    int c;
    int k;
    added = 0;
    while (added < n) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        r = ($urandom_range(3) == 0) ? $urandom_range(24, 31) : $urandom_range(31);
        case ($urandom_range(2))
          0: c = $urandom_range(127);
          1: c = $urandom_range(70, 79);
          default: c = $urandom_range(10);
        endcase
        add_req(CMD_SET, $urandom_range(255), r, c);
        k = $urandom_range(1, 12);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(9) == 0)
            add_req(CMD_PUT, NEWLINE_CODE, $urandom_range(31), $urandom_range(127));
          else
            add_req(CMD_PUT, $urandom_range(255), $urandom_range(31), $urandom_range(127));
        end
        add_req(CMD_READ, $urandom_range(255), r, c);
        if ($urandom_range(1) == 0) begin
          add_req(CMD_READ, $urandom_range(255), $urandom_range(31), $urandom_range(127));
          added++;
        end
        added += k + 2;
      end else if (sel < 72) begin
        add_req(CMD_CLEAR, $urandom_range(255), $urandom_range(31), $urandom_range(127));
        added++;
      end else begin
        add_req(cmd_t'($urandom_range(3)), $urandom_range(255), $urandom_range(31),
                $urandom_range(127));
        added++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = {ATTR_RESET, SPACE_CODE};
    cur_row = 0;
    cur_col = 0;
    shadow_attr = ATTR_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset attribute.
    @(negedge clk);
    add_req(CMD_READ, 0, 0, 0);
    add_req(CMD_PUT, 8'h41, 0, 0);
    add_req(CMD_PUT, 0, 31, 127);
    add_req(CMD_PUT, 255, 0, 0);
    add_req(CMD_READ, 0, 0, 1);
    add_req(CMD_READ, 255, 0, 2);
    add_req(CMD_SET, 0, 31, 127);
    add_req(CMD_READ, 0, 31, 127);
    // Writing the last cell wraps on the last row and scrolls.
    add_req(CMD_PUT, 8'h5A, 0, 0);
    add_req(CMD_READ, 0, 23, 79);
    add_req(CMD_READ, 0, 24, 79);
    add_req(CMD_SET, 0, 24, 5);
    add_req(CMD_PUT, NEWLINE_CODE, 0, 0);
    add_req(CMD_READ, 0, 22, 79);
    add_req(CMD_SET, 0, 3, 79);
    add_req(CMD_PUT, 8'h78, 0, 0);
    add_req(CMD_PUT, NEWLINE_CODE, 0, 0);
    add_req(CMD_READ, 0, 3, 79);
    add_req(CMD_CLEAR, 0, 0, 0);
    add_req(CMD_READ, 0, 10, 10);
    add_req(CMD_SET, 0, 31, 0);
    add_req(CMD_SET, 0, 0, 127);
    add_req(CMD_PUT, 8'h20, 0, 0);
    wait_console_idle();

    write_text_attribute(8'hFF);
    @(negedge clk);
    phase = 1;
    gen_random_phase(RANDOM_PER_PHASE);
    wait_console_idle();

    write_text_attribute(8'h00);
    @(negedge clk);
    phase = 2;
    gen_random_phase(RANDOM_PER_PHASE);
    wait_console_idle();

    write_text_attribute(ATTR_W'($urandom_range(1, 254)));
    @(negedge clk);
    phase = 3;
    gen_random_phase(RANDOM_PER_PHASE);
    wait_console_idle();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("text_console_writer: match");
    end else begin
      $display("text_console_writer: mismatch");
    end
    $finish;
  end

endmodule
